// ----- rtl/t2mi_pkg.sv -----
package t2mi_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 14;
  localparam int LENGTH_W  = 16;
  localparam int CRC_W     = 32;
  localparam int FAIL_W    = 2;

  // Expected length needs one bit over the count
  localparam int EXPECT_W  = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int TRAILER_BYTES = 4;
  localparam int HEADER_BYTES_DEFAULT = 6;

  // Header bytes that carry the payload bit length, big-endian
  localparam logic [COUNT_W-1:0] LEN_HI_POS = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] LEN_LO_POS = COUNT_W'(5);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [FAIL_W-1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_SHORT  = 2'd1,
    FAIL_LENGTH = 2'd2,
    FAIL_CRC    = 2'd3
  } fail_code_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic                packet_ok;
    fail_code_t          fail_code;
    logic [COUNT_W-1:0]  total_bytes;
  } verdict_t;

  // MSB-first CRC-32 update over one byte
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/t2mi_if.sv -----
interface t2mi_byte_if;
  logic                     valid;
  logic                     ready;
  logic [t2mi_pkg::BYTE_W-1:0] data_byte;
  logic                     last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface t2mi_verdict_if;
  logic                         valid;
  logic                         ready;
  logic                         packet_ok;
  logic [t2mi_pkg::FAIL_W-1:0]  fail_code;
  logic [t2mi_pkg::COUNT_W-1:0] total_bytes;

  modport source (output valid, output packet_ok, output fail_code, output total_bytes,
                  input ready);
  modport sink   (input valid, input packet_ok, input fail_code, input total_bytes,
                  output ready);
endinterface

// ----- rtl/t2mi_packet_validator_unit.sv -----
// Channel   Modport  Payload                                   Meaning
// bytes     sink     data_byte[7:0], last_byte                 packet bytes, header first
// verdicts  source   packet_ok, fail_code[1:0], total_bytes    one verdict per packet
//
// One byte is taken per cycle unless stalled; a verdict goes via the stage and output registers.
// The byte-wide CRC-32 update between the input and state registers sets the cycle.
// rst is synchronous, active high, and empties both stages and restarts the packet.
// A stalled verdict holds the output register; bytes keep flowing until a second
// final byte would need it, then bytes stall too.
module t2mi_packet_validator_unit #(
  parameter int HEADER_BYTES = t2mi_pkg::HEADER_BYTES_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  t2mi_byte_if.sink        bytes,
  t2mi_verdict_if.source   verdicts
);
  import t2mi_pkg::*;

  logic     stage_valid;
  item_t    stage;
  logic     out_valid;
  verdict_t out_q;
  verdict_t verdict;
  logic     out_free;
  logic     fire;

  // A byte moves on unless it is final and the result register is taken
  assign out_free    = !out_valid || verdicts.ready;
  assign fire        = stage_valid && (!stage.last_byte || out_free);
  assign bytes.ready = !stage_valid || fire;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (bytes.ready) begin
      stage_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      stage.data_byte <= bytes.data_byte;
      stage.last_byte <= bytes.last_byte;
    end
  end

  t2mi_accum #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (stage),
    .verdict (verdict)
  );

  // Load the verdict register on a final byte; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && stage.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stage.last_byte) begin
      out_q <= verdict;
    end
  end

  assign verdicts.valid       = out_valid;
  assign verdicts.packet_ok   = out_q.packet_ok;
  assign verdicts.fail_code   = out_q.fail_code;
  assign verdicts.total_bytes = out_q.total_bytes;

`ifndef SYNTHESIS
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_q.packet_ok == (out_q.fail_code == FAIL_NONE))
    else $error("packet_ok disagrees with fail_code");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_q.total_bytes != '0)
    else $error("verdict for an empty packet");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !fire |=> stage_valid && $stable(stage))
    else $error("stalled byte lost");

  a_short_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.fail_code == FAIL_SHORT |-> out_q.total_bytes < COUNT_W'(HEADER_BYTES))
    else $error("short verdict on a full header");
`endif

endmodule

// ----- rtl/t2mi_accum.sv -----
module t2mi_accum #(
  parameter int HEADER_BYTES = t2mi_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  t2mi_pkg::item_t    item,
  output t2mi_pkg::verdict_t verdict
);
  import t2mi_pkg::*;

  logic [CRC_W-1:0]    crc;
  logic [COUNT_W-1:0]  count;
  logic [LENGTH_W-1:0] length;

  logic [CRC_W-1:0]    crc_next;
  logic [COUNT_W-1:0]  count_next;
  logic [LENGTH_W-1:0] length_next;
  logic [COUNT_W-1:0]  ceil_bytes;
  logic [EXPECT_W-1:0] expected;

  // Fold the request into the running packet state
  always_comb begin
    crc_next    = crc_feed(crc, item.data_byte);
    count_next  = (count == COUNT_MAX) ? count : count + COUNT_W'(1);
    length_next = length;
    if (count == LEN_HI_POS) begin
      length_next = {item.data_byte, length[BYTE_W-1:0]};
    end else if (count == LEN_LO_POS) begin
      length_next = {length[LENGTH_W-1:BYTE_W], item.data_byte};
    end
  end

  // Judge the packet on its final byte: short, then length, then CRC
  always_comb begin
    logic [LENGTH_W:0] rounded;
    rounded    = {1'b0, length_next} + (LENGTH_W+1)'(7);
    ceil_bytes = rounded[LENGTH_W:3];
    expected   = EXPECT_W'(HEADER_BYTES + TRAILER_BYTES) + EXPECT_W'(ceil_bytes);
    if (count_next < COUNT_W'(HEADER_BYTES)) begin
      verdict.fail_code = FAIL_SHORT;
    end else if ({1'b0, count_next} != expected) begin
      verdict.fail_code = FAIL_LENGTH;
    end else if (crc_next != '0) begin
      verdict.fail_code = FAIL_CRC;
    end else begin
      verdict.fail_code = FAIL_NONE;
    end
    verdict.packet_ok   = (verdict.fail_code == FAIL_NONE);
    verdict.total_bytes = count_next;
  end

  // Advance on each request; restart after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc    <= CRC_INIT;
      count  <= '0;
      length <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        crc    <= CRC_INIT;
        count  <= '0;
        length <= '0;
      end else begin
        crc    <= crc_next;
        count  <= count_next;
        length <= length_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_byte |=> count == '0 && crc == CRC_INIT && length == '0)
    else $error("state not cleared after final byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && !item.last_byte && count != COUNT_MAX |=> count == $past(count) + COUNT_W'(1))
    else $error("byte count did not advance");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    fire && !item.last_byte && count == COUNT_MAX |=> count == COUNT_MAX)
    else $error("saturated byte count moved");
`endif

endmodule
